// ----- hdl/calendar_date_difference_macros.svh -----
// Assertion macros used by the calendar date difference top level.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef CALENDAR_DATE_DIFFERENCE_MACROS_SVH
`define CALENDAR_DATE_DIFFERENCE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cdd_pkg.sv -----
// ----------------------------------------------------------------------------
// cdd_pkg
// Shared widths, sequencer codes and controller/datapath interface types for
// the calendar date difference block.
// ----------------------------------------------------------------------------
package cdd_pkg;

  // Field widths of the request and result.
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned DAY_W  = 5;

  // Width of a day count; covers every 14-bit year.
  localparam int unsigned CNT_W = 23;

  // Restoring-division steps for whole 400-year cycles and 4-year groups.
  localparam int unsigned STEP_W    = 3;
  localparam int unsigned CYC_STEPS = 6;
  localparam int unsigned GRP_STEPS = 5;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PRE,
    OP_SUM,
    OP_TOT,
    OP_DIFF,
    OP_CYCLE,
    OP_CENT,
    OP_GRP0,
    OP_GRP,
    OP_YEAR,
    OP_MONTH,
    OP_PUBLISH
  } op_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_SUM,
    ST_TOT,
    ST_DIFF,
    ST_CYC,
    ST_CENT,
    ST_GRP,
    ST_YEAR,
    ST_MON
  } state_e;

  // Command from controller to datapath.
  typedef struct packed {
    op_e               op;
    logic [STEP_W-1:0] shift;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic cent_fit;
    logic yr_fit;
    logic mon_fit;
  } sts_t;

endpackage

// ----- hdl/cdd_dpath.sv -----
// ----------------------------------------------------------------------------
// cdd_dpath
// Datapath: converts both dates to day counts, takes the distance and lays it
// out again as years, month and days by stepwise subtraction.
// ----------------------------------------------------------------------------
module cdd_dpath #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                       clk_i,
  input  logic [cdd_pkg::YEAR_W-1:0] first_year_i,
  input  logic [cdd_pkg::MON_W-1:0]  first_month_i,
  input  logic [cdd_pkg::DAY_W-1:0]  first_day_i,
  input  logic [cdd_pkg::YEAR_W-1:0] second_year_i,
  input  logic [cdd_pkg::MON_W-1:0]  second_month_i,
  input  logic [cdd_pkg::DAY_W-1:0]  second_day_i,
  input  cdd_pkg::cmd_t              cmd_i,
  output cdd_pkg::sts_t              sts_o,
  output logic [cdd_pkg::YEAR_W-1:0] elapsed_years_o,
  output logic [cdd_pkg::MON_W-1:0]  elapsed_month_o,
  output logic [cdd_pkg::DAY_W-1:0]  elapsed_days_o
);
  import cdd_pkg::*;

  localparam int unsigned CycleDays  = 146097;
  localparam int unsigned CycleYears = 400;
  localparam int unsigned CentDays   = 36524;
  localparam int unsigned CentYears  = 100;
  localparam int unsigned QuadDays   = 1461;
  localparam int unsigned QuadYears  = 4;
  localparam int unsigned YearDays   = 365;
  localparam int unsigned Recip100   = 5243;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned PROD_W     = 27;
  localparam int unsigned QUO_W      = 8;
  localparam int unsigned MD_W       = 9;
  localparam int unsigned YearMax    = (1 << YEAR_W) - 1;
  localparam logic [YEAR_W-1:0] ClampYear =
    (MAX_YEAR > YearMax) ? YEAR_W'(YearMax) : YEAR_W'(MAX_YEAR);

  // Days of the months before month m in a common year.
  function automatic logic [MD_W-1:0] mon_prefix(input logic [MON_W-1:0] m);
    logic [MD_W-1:0] v;
    unique case (m)
      4'd0, 4'd1: v = 9'd0;
      4'd2:       v = 9'd31;
      4'd3:       v = 9'd59;
      4'd4:       v = 9'd90;
      4'd5:       v = 9'd120;
      4'd6:       v = 9'd151;
      4'd7:       v = 9'd181;
      4'd8:       v = 9'd212;
      4'd9:       v = 9'd243;
      4'd10:      v = 9'd273;
      4'd11:      v = 9'd304;
      4'd12:      v = 9'd334;
      4'd13:      v = 9'd365;
      4'd14:      v = 9'd395;
      default:    v = 9'd426;
    endcase
    return v;
  endfunction

  // Length of month m; odd months up to July and even months from August on
  // have 31 days.
  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] v;
    if (m == MON_W'(2)) begin
      v = leap ? 5'd29 : 5'd28;
    end else if ((m[0] && (m < MON_W'(8))) || (!m[0] && (m >= MON_W'(8)))) begin
      v = 5'd31;
    end else begin
      v = 5'd30;
    end
    return v;
  endfunction

  // Captured request.
  logic [YEAR_W-1:0] yr_q  [2];
  logic [MON_W-1:0]  mon_q [2];
  logic [DAY_W-1:0]  day_q [2];

  // Day-count pipeline registers.
  logic [YEAR_W-1:0] yc_q    [2];
  logic [CNT_W-1:0]  p365_q  [2];
  logic [QUO_W-1:0]  qp_q    [2];
  logic [QUO_W-1:0]  qy_q    [2];
  logic [CNT_W-1:0]  ydays_q [2];
  logic [MD_W-1:0]   mdays_q [2];
  logic [CNT_W-1:0]  tot_q   [2];

  // Walk state.
  logic [CNT_W-1:0]  rest_q;
  logic [YEAR_W-1:0] years_q;
  logic [MON_W-1:0]  month_q;
  logic              cent_nl_q;
  logic              grp_nl_q;
  logic              yr_first_q;

  // Result registers.
  logic [YEAR_W-1:0] res_years_q;
  logic [MON_W-1:0]  res_month_q;
  logic [DAY_W-1:0]  res_days_q;

  // Per-date combinational terms.
  logic [YEAR_W-1:0] yc_d    [2];
  logic [YEAR_W-1:0] pm      [2];
  logic [PROD_W-1:0] prod_p  [2];
  logic [PROD_W-1:0] prod_y  [2];
  logic [CNT_W-1:0]  p365_d  [2];
  logic [YEAR_W-1:0] rem100  [2];
  logic              leap    [2];
  logic [CNT_W-1:0]  ydays_d [2];
  logic [MD_W-1:0]   mdays_d [2];
  logic [CNT_W-1:0]  tot_d   [2];

  // Year clamp, previous-year count and reciprocal quotients by one hundred.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      yc_d[i]   = (32'(yr_q[i]) > MAX_YEAR) ? ClampYear : yr_q[i];
      pm[i]     = (yc_d[i] == '0) ? '0 : yc_d[i] - YEAR_W'(1);
      prod_p[i] = PROD_W'(pm[i]) * PROD_W'(Recip100);
      prod_y[i] = PROD_W'(yc_d[i]) * PROD_W'(Recip100);
      p365_d[i] = CNT_W'(pm[i]) * CNT_W'(YearDays) + CNT_W'(pm[i] >> 2);
    end
  end

  // Leap test, year days, month days and the total of each date.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem100[i]  = yc_q[i] - YEAR_W'(YEAR_W'(qy_q[i]) * YEAR_W'(CentYears));
      leap[i]    = (rem100[i] == '0) ? (qy_q[i][1:0] == 2'b00) : (yc_q[i][1:0] == 2'b00);
      ydays_d[i] = p365_q[i] - CNT_W'(qp_q[i]) + CNT_W'(qp_q[i] >> 2);
      mdays_d[i] = mon_prefix(mon_q[i]) + MD_W'(leap[i] && (mon_q[i] >= MON_W'(3)))
                   + MD_W'(day_q[i]);
      tot_d[i]   = ydays_q[i] + CNT_W'(mdays_q[i]);
    end
  end

  // Absolute distance of the two counts.
  logic             a_ge_b;
  logic [CNT_W-1:0] diff;
  assign a_ge_b = tot_q[0] >= tot_q[1];
  assign diff   = a_ge_b ? (tot_q[0] - tot_q[1]) : (tot_q[1] - tot_q[0]);

  // Chunk lengths used by the walk.
  logic [CNT_W-1:0]  cyc_len;
  logic [CNT_W-1:0]  cent_len;
  logic [CNT_W-1:0]  grp0_len;
  logic [CNT_W-1:0]  grp_len;
  logic              yr_leap;
  logic [CNT_W-1:0]  yr_len;
  logic [CNT_W-1:0]  mlen;

  assign cyc_len  = CNT_W'(CycleDays) << cmd_i.shift;
  assign cent_len = cent_nl_q ? CNT_W'(CentDays) : CNT_W'(CentDays + 1);
  assign grp0_len = cent_nl_q ? CNT_W'(QuadDays - 1) : CNT_W'(QuadDays);
  assign grp_len  = CNT_W'(QuadDays) << cmd_i.shift;
  assign yr_leap  = yr_first_q && !grp_nl_q;
  assign yr_len   = yr_leap ? CNT_W'(YearDays + 1) : CNT_W'(YearDays);
  assign mlen     = CNT_W'(month_len(yr_leap, month_q));

  assign sts_o.cent_fit = rest_q < cent_len;
  assign sts_o.yr_fit   = rest_q < yr_len;
  assign sts_o.mon_fit  = rest_q < mlen;

  // Datapath registers, updated by the command of the cycle.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        yr_q[0]  <= first_year_i;
        mon_q[0] <= first_month_i;
        day_q[0] <= first_day_i;
        yr_q[1]  <= second_year_i;
        mon_q[1] <= second_month_i;
        day_q[1] <= second_day_i;
      end
      OP_PRE: begin
        for (int i = 0; i < 2; i++) begin
          yc_q[i]   <= yc_d[i];
          p365_q[i] <= p365_d[i];
          qp_q[i]   <= prod_p[i][RecipShift +: QUO_W];
          qy_q[i]   <= prod_y[i][RecipShift +: QUO_W];
        end
      end
      OP_SUM: begin
        for (int i = 0; i < 2; i++) begin
          ydays_q[i] <= ydays_d[i];
          mdays_q[i] <= mdays_d[i];
        end
      end
      OP_TOT: begin
        for (int i = 0; i < 2; i++) begin
          tot_q[i] <= tot_d[i];
        end
      end
      OP_DIFF: begin
        rest_q     <= diff;
        years_q    <= '0;
        month_q    <= MON_W'(1);
        cent_nl_q  <= 1'b0;
        grp_nl_q   <= 1'b0;
        yr_first_q <= 1'b1;
      end
      OP_CYCLE: begin
        if (rest_q >= cyc_len) begin
          rest_q  <= rest_q - cyc_len;
          years_q <= years_q + (YEAR_W'(CycleYears) << cmd_i.shift);
        end
      end
      OP_CENT: begin
        if (!sts_o.cent_fit) begin
          rest_q    <= rest_q - cent_len;
          years_q   <= years_q + YEAR_W'(CentYears);
          cent_nl_q <= 1'b1;
        end
      end
      OP_GRP0: begin
        // The first 4-year group of a later century lacks its leap day.
        if (rest_q >= grp0_len) begin
          rest_q   <= rest_q - grp0_len;
          years_q  <= years_q + YEAR_W'(QuadYears);
          grp_nl_q <= 1'b0;
        end else begin
          grp_nl_q <= cent_nl_q;
        end
      end
      OP_GRP: begin
        if (rest_q >= grp_len) begin
          rest_q   <= rest_q - grp_len;
          years_q  <= years_q + (YEAR_W'(QuadYears) << cmd_i.shift);
          grp_nl_q <= 1'b0;
        end
      end
      OP_YEAR: begin
        if (!sts_o.yr_fit) begin
          rest_q     <= rest_q - yr_len;
          years_q    <= years_q + YEAR_W'(1);
          yr_first_q <= 1'b0;
        end
      end
      OP_MONTH: begin
        if (!sts_o.mon_fit) begin
          rest_q  <= rest_q - mlen;
          month_q <= month_q + MON_W'(1);
        end
      end
      OP_PUBLISH: begin
        res_years_q <= years_q;
        res_month_q <= month_q;
        res_days_q  <= rest_q[DAY_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign elapsed_years_o = res_years_q;
  assign elapsed_month_o = res_month_q;
  assign elapsed_days_o  = res_days_q;

endmodule

// ----- hdl/cdd_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdd_ctrl
// Controller: sequences the datapath through the day counts and the walk,
// and owns the request and result handshakes.
// ----------------------------------------------------------------------------
module cdd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cdd_pkg::cmd_t cmd_o,
  input  cdd_pkg::sts_t sts_i
);
  import cdd_pkg::*;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;

  // State, step counter and result valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_o.op     = OP_NONE;
    cmd_o.shift  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_PRE;
        end
      end
      ST_PRE: begin
        cmd_o.op = OP_PRE;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = ST_TOT;
      end
      ST_TOT: begin
        cmd_o.op = OP_TOT;
        state_d  = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.op = OP_DIFF;
        step_d   = STEP_W'(CYC_STEPS - 1);
        state_d  = ST_CYC;
      end
      ST_CYC: begin
        cmd_o.op = OP_CYCLE;
        if (step_q == '0) begin
          state_d = ST_CENT;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      ST_CENT: begin
        // Whole centuries first, then the first 4-year group of the century.
        if (sts_i.cent_fit) begin
          cmd_o.op = OP_GRP0;
          step_d   = STEP_W'(GRP_STEPS - 1);
          state_d  = ST_GRP;
        end else begin
          cmd_o.op = OP_CENT;
        end
      end
      ST_GRP: begin
        cmd_o.op = OP_GRP;
        if (step_q == '0) begin
          state_d = ST_YEAR;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      ST_YEAR: begin
        if (sts_i.yr_fit) begin
          state_d = ST_MON;
        end else begin
          cmd_o.op = OP_YEAR;
        end
      end
      ST_MON: begin
        // Publish once the month fits and the result register is free.
        if (!sts_i.mon_fit) begin
          cmd_o.op = OP_MONTH;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_PUBLISH;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/calendar_date_difference.sv -----
// The block takes one request at a time. It forms both day counts, then walks
// the distance to a result with one subtraction per cycle over 400-year
// cycles, centuries, 4-year groups, years and months. A finished result
// waits in its own register while the next request is taken. Reset clears
// the controller and the result valid; there is no clearing pass.
// ----------------------------------------------------------------------------
// calendar_date_difference
// Distance between two Gregorian dates, given as full years, a month
// numbered from one and the remaining days.
// ----------------------------------------------------------------------------
`include "calendar_date_difference_macros.svh"

module calendar_date_difference #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cdd_pkg::YEAR_W-1:0] first_year_i,
  input  logic [cdd_pkg::MON_W-1:0]  first_month_i,
  input  logic [cdd_pkg::DAY_W-1:0]  first_day_i,
  input  logic [cdd_pkg::YEAR_W-1:0] second_year_i,
  input  logic [cdd_pkg::MON_W-1:0]  second_month_i,
  input  logic [cdd_pkg::DAY_W-1:0]  second_day_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [cdd_pkg::YEAR_W-1:0] elapsed_years_o,
  output logic [cdd_pkg::MON_W-1:0]  elapsed_month_o,
  output logic [cdd_pkg::DAY_W-1:0]  elapsed_days_o
);
  import cdd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  cdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Arithmetic and result registers.
  cdd_dpath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dpath (
    .clk_i           (clk_i),
    .first_year_i    (first_year_i),
    .first_month_i   (first_month_i),
    .first_day_i     (first_day_i),
    .second_year_i   (second_year_i),
    .second_month_i  (second_month_i),
    .second_day_i    (second_day_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .elapsed_years_o (elapsed_years_o),
    .elapsed_month_o (elapsed_month_o),
    .elapsed_days_o  (elapsed_days_o)
  );

  // Terms watched by the assertions.
  logic month_in_range;
  logic in_accept;
  assign month_in_range = (elapsed_month_o >= 4'd1) && (elapsed_month_o <= 4'd12);
  assign in_accept      = in_valid_i && in_ready_o;

  // A published month is always a real month and the days are at most 30.
  `CDD_ASSERT_SAME(a_month_range, out_valid_o, month_in_range, "elapsed month out of range")
  `CDD_ASSERT_SAME(a_days_range, out_valid_o, elapsed_days_o <= 5'd30, "elapsed days out of range")
  // An accepted request keeps the block busy for at least the next cycle.
  `CDD_ASSERT_NEXT(a_busy_after_accept, in_accept, !in_ready_o, "request taken while busy")

endmodule

// ----- tb/calendar_date_difference_checker.sv -----
// ----------------------------------------------------------------------------
// calendar_date_difference_checker
// Watches the request and result channels of the date difference block. It
// computes the expected span for every accepted request and compares each
// accepted result against the oldest expected span, field by field.
// ----------------------------------------------------------------------------
module calendar_date_difference_checker #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [cdd_pkg::YEAR_W-1:0] first_year_i,
  input  logic [cdd_pkg::MON_W-1:0]  first_month_i,
  input  logic [cdd_pkg::DAY_W-1:0]  first_day_i,
  input  logic [cdd_pkg::YEAR_W-1:0] second_year_i,
  input  logic [cdd_pkg::MON_W-1:0]  second_month_i,
  input  logic [cdd_pkg::DAY_W-1:0]  second_day_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [cdd_pkg::YEAR_W-1:0] elapsed_years_i,
  input  logic [cdd_pkg::MON_W-1:0]  elapsed_month_i,
  input  logic [cdd_pkg::DAY_W-1:0]  elapsed_days_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import cdd_pkg::*;

  // Calendar constants.
  localparam int unsigned CYCLE_YEARS = 400;
  localparam int unsigned CYCLE_DAYS  = 146097;
  localparam int unsigned FEBRUARY    = 2;
  localparam int unsigned AUGUST      = 8;

  // One elapsed span as the block reports it.
  typedef struct packed {
    logic [YEAR_W-1:0] years;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  days;
  } span_t;

  span_t span_q[$];
  int    fail_count;

  function automatic bit is_leap(int unsigned year);
    return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
  endfunction

  // Month lengths; months past 12 keep the alternation of August onward.
  function automatic int unsigned month_days(int unsigned year, int unsigned month);
    if (month == FEBRUARY) begin
      return is_leap(year) ? 29 : 28;
    end
    if ((month[0] && month < AUGUST) || (!month[0] && month >= AUGUST)) begin
      return 31;
    end
    return 30;
  endfunction

  // Days from the start of the calendar up to and including the given date.
  function automatic int unsigned day_number(logic [YEAR_W-1:0] year,
                                             logic [MON_W-1:0] month,
                                             logic [DAY_W-1:0] day);
    int unsigned y;
    int unsigned p;
    int unsigned total;
    int unsigned k;
    y = 32'(year);
    if (y > MAX_YEAR) begin
      y = MAX_YEAR;
    end
    total = 32'(day);
    if (y >= 1) begin
      p = y - 1;
      total += 365 * p + p / 4 - p / 100 + p / 400;
    end
    for (k = 1; k < 32'(month); k++) begin
      total += month_days(y, k);
    end
    return total;
  endfunction

  // Lays the distance between two dates out as years, month and days.
  function automatic span_t date_span(logic [YEAR_W-1:0] fy, logic [MON_W-1:0] fm,
                                      logic [DAY_W-1:0] fd, logic [YEAR_W-1:0] sy,
                                      logic [MON_W-1:0] sm, logic [DAY_W-1:0] sd);
    int unsigned a;
    int unsigned b;
    int unsigned rest;
    int unsigned years;
    int unsigned k;
    int unsigned m;
    span_t       span;
    a    = day_number(fy, fm, fd);
    b    = day_number(sy, sm, sd);
    rest = (a >= b) ? a - b : b - a;
    years = (rest / CYCLE_DAYS) * CYCLE_YEARS;
    rest  = rest % CYCLE_DAYS;
    // Whole years inside one 400-year cycle, then whole months of that year.
    k = 0;
    while (rest >= (is_leap(k) ? 366 : 365)) begin
      rest -= is_leap(k) ? 366 : 365;
      k++;
    end
    years += k;
    m = 1;
    while (rest >= month_days(k, m)) begin
      rest -= month_days(k, m);
      m++;
    end
    span.years = years[YEAR_W-1:0];
    span.month = m[MON_W-1:0];
    span.days  = rest[DAY_W-1:0];
    return span;
  endfunction

  // Compare results first so a result never matches the request of this edge.
  always @(posedge clk_i or negedge rst_ni) begin
    span_t want;
    if (!rst_ni) begin
      span_q.delete();
      fail_count   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (span_q.size() == 0) begin
          fail_count++;
          $error("result %0d/%0d/%0d arrived with no request outstanding",
                 elapsed_years_i, elapsed_month_i, elapsed_days_i);
        end else begin
          want = span_q.pop_front();
          if (want.years !== elapsed_years_i) begin
            fail_count++;
            $error("elapsed_years: expected %0d, got %0d", want.years, elapsed_years_i);
          end
          if (want.month !== elapsed_month_i) begin
            fail_count++;
            $error("elapsed_month: expected %0d, got %0d", want.month, elapsed_month_i);
          end
          if (want.days !== elapsed_days_i) begin
            fail_count++;
            $error("elapsed_days: expected %0d, got %0d", want.days, elapsed_days_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        span_q.push_back(date_span(first_year_i, first_month_i, first_day_i,
                                   second_year_i, second_month_i, second_day_i));
      end
      fail_count_o <= fail_count;
      pending_o    <= span_q.size();
    end
  end

endmodule

// ----- tb/calendar_date_difference_tb.sv -----
// ----------------------------------------------------------------------------
// calendar_date_difference_tb
// Drives date pairs into the date difference block: a directed set of edge
// dates first, then random pairs under several idle and stall patterns. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module calendar_date_difference_tb;
  import cdd_pkg::*;

  localparam int unsigned MAX_YEAR    = 9999;
  localparam int unsigned ITEMS_PHASE = 220;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int          CYCLE_LIMIT = 1000000;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [YEAR_W-1:0] first_year_i   = '0;
  logic [MON_W-1:0]  first_month_i  = '0;
  logic [DAY_W-1:0]  first_day_i    = '0;
  logic [YEAR_W-1:0] second_year_i  = '0;
  logic [MON_W-1:0]  second_month_i = '0;
  logic [DAY_W-1:0]  second_day_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [YEAR_W-1:0] elapsed_years_o;
  logic [MON_W-1:0]  elapsed_month_o;
  logic [DAY_W-1:0]  elapsed_days_o;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  calendar_date_difference #(
    .MAX_YEAR(MAX_YEAR)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .first_year_i   (first_year_i),
    .first_month_i  (first_month_i),
    .first_day_i    (first_day_i),
    .second_year_i  (second_year_i),
    .second_month_i (second_month_i),
    .second_day_i   (second_day_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .elapsed_years_o(elapsed_years_o),
    .elapsed_month_o(elapsed_month_o),
    .elapsed_days_o (elapsed_days_o)
  );

  calendar_date_difference_checker #(
    .MAX_YEAR(MAX_YEAR)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .first_year_i   (first_year_i),
    .first_month_i  (first_month_i),
    .first_day_i    (first_day_i),
    .second_year_i  (second_year_i),
    .second_month_i (second_month_i),
    .second_day_i   (second_day_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .elapsed_years_i(elapsed_years_o),
    .elapsed_month_i(elapsed_month_o),
    .elapsed_days_i (elapsed_days_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The receiver stalls at random with the probability of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one request and returns right after the edge that accepts it.
  task automatic send_dates(input logic [YEAR_W-1:0] fy, input logic [MON_W-1:0] fm,
                            input logic [DAY_W-1:0] fd, input logic [YEAR_W-1:0] sy,
                            input logic [MON_W-1:0] sm, input logic [DAY_W-1:0] sd);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    first_year_i   <= fy;
    first_month_i  <= fm;
    first_day_i    <= fd;
    second_year_i  <= sy;
    second_month_i <= sm;
    second_day_i   <= sd;
    do begin
      @(posedge clk_i);
    end while (!(in_valid_i && in_ready_o));
  endtask

  // Mostly plausible dates, some close pairs, and some raw bit patterns.
  task automatic send_random_dates();
    logic [YEAR_W-1:0] fy;
    logic [YEAR_W-1:0] sy;
    logic [MON_W-1:0]  fm;
    logic [MON_W-1:0]  sm;
    logic [DAY_W-1:0]  fd;
    logic [DAY_W-1:0]  sd;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      fy = YEAR_W'($urandom);
      fm = MON_W'($urandom);
      fd = DAY_W'($urandom);
      sy = YEAR_W'($urandom);
      sm = MON_W'($urandom);
      sd = DAY_W'($urandom);
    end else begin
      fy = YEAR_W'($urandom_range(MAX_YEAR));
      fm = MON_W'($urandom_range(12, 1));
      fd = ($urandom_range(3) == 0) ? DAY_W'($urandom_range(31, 1))
                                    : DAY_W'($urandom_range(28, 1));
      sm = MON_W'($urandom_range(12, 1));
      sd = ($urandom_range(3) == 0) ? DAY_W'($urandom_range(31, 1))
                                    : DAY_W'($urandom_range(28, 1));
      if (pick < 50) begin
        // Close pairs give short spans that end inside the first years.
        sy = (32'(fy) < MAX_YEAR) ? fy + YEAR_W'($urandom_range(1)) : fy;
      end else begin
        sy = YEAR_W'($urandom_range(MAX_YEAR));
      end
    end
    if ($urandom_range(1) == 0) begin
      send_dates(fy, fm, fd, sy, sm, sd);
    end else begin
      send_dates(sy, sm, sd, fy, fm, fd);
    end
  endtask

  // Holds the sender until every outstanding result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending != 0);
  endtask

  initial begin
    int idle_by_phase[4];
    int stall_by_phase[4];
    idle_by_phase  = '{0, 87, 0, 15};
    stall_by_phase = '{0, 0, 87, 15};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed dates: equal dates, extremes, leap rules and malformed fields.
    send_dates(14'd2000, 4'd1, 5'd1, 14'd2000, 4'd1, 5'd1);
    send_dates(14'd0, 4'd1, 5'd1, 14'd9999, 4'd12, 5'd31);
    send_dates(14'd9999, 4'd12, 5'd31, 14'd0, 4'd1, 5'd1);
    send_dates(14'd16383, 4'd15, 5'd31, 14'd0, 4'd0, 5'd0);
    send_dates(14'd16383, 4'd0, 5'd0, 14'd0, 4'd15, 5'd31);
    send_dates(14'd10000, 4'd1, 5'd1, 14'd9999, 4'd1, 5'd1);
    send_dates(14'd2000, 4'd2, 5'd29, 14'd2000, 4'd3, 5'd1);
    send_dates(14'd1900, 4'd2, 5'd28, 14'd1900, 4'd3, 5'd1);
    send_dates(14'd2024, 4'd2, 5'd29, 14'd2023, 4'd2, 5'd28);
    send_dates(14'd2023, 4'd0, 5'd5, 14'd2023, 4'd1, 5'd5);
    send_dates(14'd2023, 4'd13, 5'd1, 14'd2023, 4'd14, 5'd1);
    send_dates(14'd2023, 4'd15, 5'd1, 14'd2023, 4'd12, 5'd31);
    send_dates(14'd2023, 4'd4, 5'd0, 14'd2023, 4'd3, 5'd31);
    send_dates(14'd2023, 4'd2, 5'd31, 14'd2023, 4'd3, 5'd3);
    send_dates(14'd1, 4'd1, 5'd1, 14'd0, 4'd1, 5'd1);
    send_dates(14'd0, 4'd12, 5'd31, 14'd0, 4'd1, 5'd1);
    send_dates(14'd400, 4'd1, 5'd1, 14'd0, 4'd1, 5'd1);
    send_dates(14'd2000, 4'd1, 5'd1, 14'd1999, 4'd12, 5'd31);
    send_dates(14'd1, 4'd1, 5'd1, 14'd401, 4'd1, 5'd1);
    send_dates(14'd8191, 4'd10, 5'd21, 14'd5461, 4'd5, 5'd10);
    send_dates(14'd10922, 4'd5, 5'd10, 14'd5461, 4'd10, 5'd21);
    send_dates(14'd1600, 4'd12, 5'd31, 14'd1601, 4'd1, 5'd1);

    // Random phases, each with its own idle and stall pattern; the sender
    // drains the block completely between phases.
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct     = idle_by_phase[phase];
      receiver_stall_pct <= stall_by_phase[phase];
      for (int n = 0; n < ITEMS_PHASE; n++) begin
        send_random_dates();
      end
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- calendar_date_difference.f -----
+incdir+hdl
hdl/cdd_pkg.sv
hdl/cdd_dpath.sv
hdl/cdd_ctrl.sv
hdl/calendar_date_difference.sv
tb/calendar_date_difference_checker.sv
tb/calendar_date_difference_tb.sv
